/* rtl/core/lnbp_pkg.sv */
// Package for the linear network back-propagation trainer.
// Holds the Q16.16 widths, mode codes, stream layout and saturating helpers.
// No dependencies.
package lnbp_pkg;

    // Data width of every weight, sample and result field.
    localparam int unsigned DATA_W = 32;
    localparam int unsigned PROD_W = 2 * DATA_W;

    // Default number of hidden units.
    localparam int unsigned HIDDEN_UNITS_DEF = 8;

    // Width of the load index field.
    localparam int unsigned WIDX_W = 3;

    // Mode codes carried in the slave tuser.
    localparam int unsigned MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_INFER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRAIN = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd2;

    // Slave tdata layout, lowest bit first.
    localparam int unsigned S_SAMPLE_LSB = 0;
    localparam int unsigned S_TARGET_LSB = S_SAMPLE_LSB + DATA_W;
    localparam int unsigned S_WIDX_LSB   = S_TARGET_LSB + DATA_W;
    localparam int unsigned S_WH_LSB     = S_WIDX_LSB + WIDX_W;
    localparam int unsigned S_WO_LSB     = S_WH_LSB + DATA_W;
    localparam int unsigned S_USED_W     = S_WO_LSB + DATA_W;
    localparam int unsigned S_TDATA_W    = ((S_USED_W + 7) / 8) * 8;

    // Master tdata layout, lowest bit first.
    localparam int unsigned M_TDATA_W = 2 * DATA_W;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = {{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        lo = {{(PROD_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
        if (v > hi)
        begin
            sat32 = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (v < lo)
        begin
            sat32 = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            sat32 = v[DATA_W-1:0];
        end
    endfunction

    // Sign-extend a 32-bit value to the product width.
    function automatic logic signed [PROD_W-1:0] sext(input logic signed [DATA_W-1:0] v);
        sext = {{(PROD_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    // Product shifted down by 16 (Q16.16 times Q16.16), then saturated.
    function automatic logic signed [DATA_W-1:0] sat_q16(input logic signed [PROD_W-1:0] p);
        sat_q16 = sat32(p >>> 16);
    endfunction

    // Product shifted down by 30 (Q2.30 times Q16.16), then saturated.
    function automatic logic signed [DATA_W-1:0] sat_q30(input logic signed [PROD_W-1:0] p);
        sat_q30 = sat32(p >>> 30);
    endfunction

    // Saturating 32-bit addition.
    function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
        sat_add = sat32(sext(a) + sext(b));
    endfunction

endpackage

/* rtl/core/linear_net_backprop_step.sv */
// Top level of the linear network back-propagation trainer.
// Two weight memories, one shared 32x32 multiplier and a sequencer.
// Depends on lnbp_pkg.
//
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+----------------------------------------
// slave    | in        | s_tvalid / s_tready  | s_tuser: mode; s_tdata: sample, target,
//          |           |                      |   weight_index, hidden/output weight
// master   | out       | m_tvalid / m_tready  | m_tdata: prediction, error
// cfg      | in        | cfg_we               | cfg_wdata: learning_rate (Q2.30)
//
// One request at a time. Infer and load requests run the forward pass; train requests also
// run the update pass (N = HIDDEN_UNITS units each): the forward pass steps through FH, FO
// and FACC per unit and the update pass through UH, UGO, UDO and UWR, both bound by the single shared multiplier.
// Reset clears the learning rate and the per-entry valid bits, so every weight reads as zero
// straight after reset. A stalled master side holds the result; no new request is accepted
// while a finished result waits for the output register.
module linear_net_backprop_step #(
    parameter int unsigned HIDDEN_UNITS = lnbp_pkg::HIDDEN_UNITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write: learning_rate.
    input  logic                           cfg_we,
    input  logic [lnbp_pkg::DATA_W-1:0]    cfg_wdata,
    // Slave side.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata fields from bit 0: sample[31:0], target[63:32], weight_index[66:64],
    // hidden_weight_value[98:67], output_weight_value[130:99], zero pad[135:131].
    input  logic [lnbp_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser fields from bit 0: mode[1:0].
    input  logic [lnbp_pkg::MODE_W-1:0]    s_tuser,
    // Master side.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata fields from bit 0: prediction[31:0], error[63:32].
    output logic [lnbp_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int unsigned DW    = lnbp_pkg::DATA_W;
    localparam int unsigned PW    = lnbp_pkg::PROD_W;
    localparam int unsigned IDX_W = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
    localparam int unsigned ACC_W = DW + $clog2(HIDDEN_UNITS) + 1;
    localparam int unsigned CMP_W = 7;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HIDDEN_UNITS - 1);

    // Sequencer states.
    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_FH     = 13'b0000000000010,
        ST_FO     = 13'b0000000000100,
        ST_FACC   = 13'b0000000001000,
        ST_FEND   = 13'b0000000010000,
        ST_TDELTA = 13'b0000000100000,
        ST_TGH    = 13'b0000001000000,
        ST_TGS    = 13'b0000010000000,
        ST_TDH    = 13'b0000100000000,
        ST_UH     = 13'b0001000000000,
        ST_UGO    = 13'b0010000000000,
        ST_UDO    = 13'b0100000000000,
        ST_UWR    = 13'b1000000000000
    } state_t;

    // The result stage is a flag of its own so that the state list stays within the
    // work of the item; it marks a finished result waiting for the output register.
    state_t                      state_reg, state_next;
    logic                        pend_reg, pend_next;

    logic [IDX_W-1:0]            n_reg, n_next;
    logic [lnbp_pkg::MODE_W-1:0] mode_reg;
    logic signed [DW-1:0]        x_reg;
    logic signed [DW-1:0]        target_reg;
    logic [lnbp_pkg::WIDX_W-1:0] widx_reg;
    logic signed [DW-1:0]        ld_wh_reg;
    logic signed [DW-1:0]        ld_wo_reg;
    logic signed [DW-1:0]        eta_reg;

    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    logic signed [ACC_W-1:0]     swo_reg, swo_next;
    logic signed [DW-1:0]        pred_reg, pred_next;
    logic signed [DW-1:0]        err_reg, err_next;
    logic signed [DW-1:0]        dh_reg, dh_next;
    logic signed [PW-1:0]        prod_reg;
    logic signed [DW-1:0]        mul_a, mul_b;

    logic                        m_tvalid_reg;
    logic signed [DW-1:0]        out_pred_reg;
    logic signed [DW-1:0]        out_err_reg;

    // Weight memories and their registered read ports.
    logic signed [DW-1:0]        wh_mem [HIDDEN_UNITS];
    logic signed [DW-1:0]        wo_mem [HIDDEN_UNITS];
    logic [HIDDEN_UNITS-1:0]     valid_reg;
    logic signed [DW-1:0]        wh_q_reg, wo_q_reg;
    logic                        vq_reg;
    logic signed [DW-1:0]        wh_rd, wo_rd;

    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    logic signed [DW-1:0]        wr_wh, wr_wo;

    logic                        s_accept;
    logic                        out_free;
    logic                        load_ok;
    logic signed [DW-1:0]        pred_now;
    logic signed [PW-1:0]        acc_wide, swo_wide;
    logic [CMP_W-1:0]            widx_ext;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE) && !pend_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_err_reg, out_pred_reg};

    // Entries never written read as zero.
    assign wh_rd = vq_reg ? wh_q_reg : '0;
    assign wo_rd = vq_reg ? wo_q_reg : '0;

    assign acc_wide = {{(PW-ACC_W){acc_reg[ACC_W-1]}}, acc_reg};
    assign swo_wide = {{(PW-ACC_W){swo_reg[ACC_W-1]}}, swo_reg};
    assign pred_now = lnbp_pkg::sat32(acc_wide);
    assign widx_ext = {{(CMP_W-lnbp_pkg::WIDX_W){1'b0}}, widx_reg};
    assign load_ok  = (mode_reg == lnbp_pkg::MODE_LOAD) && (widx_ext < CMP_W'(HIDDEN_UNITS));

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        n_next     = n_reg;
        acc_next   = acc_reg;
        swo_next   = swo_reg;
        pred_next  = pred_reg;
        err_next   = err_reg;
        dh_next    = dh_reg;
        mul_a      = x_reg;
        mul_b      = wh_rd;
        wr_en      = 1'b0;
        wr_addr    = n_reg;
        wr_wh      = lnbp_pkg::sat_add(wh_rd, dh_reg);
        wr_wo      = lnbp_pkg::sat_add(wo_rd, lnbp_pkg::sat_q30(prod_reg));

        case (state_reg)
            ST_IDLE:
            begin
                n_next   = '0;
                acc_next = '0;
                swo_next = '0;
                if (pend_reg && out_free)
                begin
                    pend_next = 1'b0;
                end
                if (s_accept)
                begin
                    state_next = ST_FH;
                end
            end
            // Forward pass: h = x * wh.
            ST_FH:
            begin
                mul_a      = x_reg;
                mul_b      = wh_rd;
                state_next = ST_FO;
            end
            // Forward pass: h * wo.
            ST_FO:
            begin
                mul_a      = lnbp_pkg::sat_q16(prod_reg);
                mul_b      = wo_rd;
                state_next = ST_FACC;
            end
            // Accumulate the unit's contribution and the sum of output weights.
            ST_FACC:
            begin
                acc_next = acc_reg + ACC_W'(lnbp_pkg::sat_q16(prod_reg));
                swo_next = swo_reg + ACC_W'(wo_rd);
                if (n_reg == LAST_IDX)
                begin
                    n_next     = '0;
                    state_next = ST_FEND;
                end
                else
                begin
                    n_next     = n_reg + 1'b1;
                    state_next = ST_FH;
                end
            end
            // Prediction ready; load writes here, train goes on.
            ST_FEND:
            begin
                pred_next = pred_now;
                if (mode_reg == lnbp_pkg::MODE_TRAIN)
                begin
                    err_next   = lnbp_pkg::sat32(lnbp_pkg::sext(target_reg)
                                                 - lnbp_pkg::sext(pred_now));
                    state_next = ST_TDELTA;
                end
                else
                begin
                    err_next   = '0;
                    wr_en      = load_ok;
                    wr_addr    = widx_ext[IDX_W-1:0];
                    wr_wh      = ld_wh_reg;
                    wr_wo      = ld_wo_reg;
                    pend_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            // delta = err * sum(wo).
            ST_TDELTA:
            begin
                mul_a      = err_reg;
                mul_b      = lnbp_pkg::sat32(swo_wide);
                state_next = ST_TGH;
            end
            // Hidden gradient delta * x.
            ST_TGH:
            begin
                mul_a      = lnbp_pkg::sat_q16(prod_reg);
                mul_b      = x_reg;
                state_next = ST_TGS;
            end
            // Hidden step eta * gradient, the same for every unit.
            ST_TGS:
            begin
                mul_a      = eta_reg;
                mul_b      = lnbp_pkg::sat_q16(prod_reg);
                state_next = ST_TDH;
            end
            ST_TDH:
            begin
                dh_next    = lnbp_pkg::sat_q30(prod_reg);
                state_next = ST_UH;
            end
            // Update pass: recompute h from the old hidden weight.
            ST_UH:
            begin
                mul_a      = x_reg;
                mul_b      = wh_rd;
                state_next = ST_UGO;
            end
            // Output gradient err * h.
            ST_UGO:
            begin
                mul_a      = err_reg;
                mul_b      = lnbp_pkg::sat_q16(prod_reg);
                state_next = ST_UDO;
            end
            // Output step eta * gradient.
            ST_UDO:
            begin
                mul_a      = eta_reg;
                mul_b      = lnbp_pkg::sat_q16(prod_reg);
                state_next = ST_UWR;
            end
            // Write both updated weights of the unit back.
            ST_UWR:
            begin
                wr_en = 1'b1;
                if (n_reg == LAST_IDX)
                begin
                    n_next     = '0;
                    pend_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    n_next     = n_reg + 1'b1;
                    state_next = ST_UH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pend_reg     <= 1'b0;
            n_reg        <= '0;
            eta_reg      <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            n_reg     <= n_next;
            if (cfg_we)
            begin
                eta_reg <= cfg_wdata;
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (pend_reg && out_free && (state_reg == ST_IDLE))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            mode_reg   <= s_tuser;
            x_reg      <= s_tdata[lnbp_pkg::S_SAMPLE_LSB +: DW];
            target_reg <= s_tdata[lnbp_pkg::S_TARGET_LSB +: DW];
            widx_reg   <= s_tdata[lnbp_pkg::S_WIDX_LSB +: lnbp_pkg::WIDX_W];
            ld_wh_reg  <= s_tdata[lnbp_pkg::S_WH_LSB +: DW];
            ld_wo_reg  <= s_tdata[lnbp_pkg::S_WO_LSB +: DW];
        end
        acc_reg  <= acc_next;
        swo_reg  <= swo_next;
        pred_reg <= pred_next;
        err_reg  <= err_next;
        dh_reg   <= dh_next;
        prod_reg <= mul_a * mul_b;
        if (pend_reg && out_free && (state_reg == ST_IDLE))
        begin
            out_pred_reg <= pred_reg;
            out_err_reg  <= err_reg;
        end
    end

    // Weight memories: one write port, one registered read port at the next unit.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wh_mem[wr_addr] <= wr_wh;
            wo_mem[wr_addr] <= wr_wo;
        end
        wh_q_reg <= wh_mem[n_next];
        wo_q_reg <= wo_mem[n_next];
    end

    // Valid bit of the entry being read, registered alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vq_reg <= 1'b0;
        end
        else
        begin
            vq_reg <= valid_reg[n_next];
        end
    end

endmodule
